FILE: hdl/tvp_pkg.sv
// ----------------------------------------------------------------------------
// tvp_pkg
// Shared types, constants and arithmetic helpers of the vertex projector.
// ----------------------------------------------------------------------------
package tvp_pkg;

	// Fixed widths
	localparam int CFGW   = 24;   // configuration data width
	localparam int OFSW   = 26;   // Q8 vertex offset from the camera
	localparam int PW     = 28;   // Q8 rotation datapath
	localparam int DPW    = 21;   // whole-unit rotated coordinate
	localparam int NW     = 36;   // projection numerator
	localparam int DW     = 22;   // projection denominator
	localparam int QB     = 12;   // quotient bits, screen up to 4096
	localparam int QDEPTH = 2;    // triangle queue depth

	// Sine approximation constants, Q14
	localparam int ONE_Q14 = 16384;
	localparam int SIN_C1  = 1160;
	localparam int SIN_C2  = 10512;
	localparam int SIN_C3  = 25736;
	localparam logic [15:0] QUARTER = 16'h4000;

	// Configuration register indexes
	typedef enum logic [2:0] {
		REG_CAM_X = 3'd0,
		REG_CAM_Y = 3'd1,
		REG_CAM_Z = 3'd2,
		REG_PITCH = 3'd3,
		REG_YAW   = 3'd4,
		REG_ROLL  = 3'd5,
		REG_FOCAL = 3'd6
	} reg_idx_t;

	localparam logic [9:0] FOCAL_RESET = 10'd150;

	// Vertex slot within a triangle
	localparam logic [1:0] VTX_A = 2'd0;
	localparam logic [1:0] VTX_B = 2'd1;
	localparam logic [1:0] VTX_C = 2'd2;

	// Sine unit sequencer
	typedef enum logic [2:0] {
		TRIG_IDLE,
		TRIG_LOAD,
		TRIG_SQ,
		TRIG_P1,
		TRIG_P2,
		TRIG_P3
	} trig_state_t;

	typedef struct packed {
		logic signed [15:0] sx;
		logic signed [15:0] cx;
		logic signed [15:0] sy;
		logic signed [15:0] cy;
		logic signed [15:0] sz;
		logic signed [15:0] cz;
	} trig_t;

	typedef struct packed {
		logic signed [OFSW-1:0] x;
		logic signed [OFSW-1:0] y;
		logic signed [OFSW-1:0] z;
	} vtx_t;

	typedef struct packed {
		vtx_t a;
		vtx_t b;
		vtx_t c;
	} tri_t;

	// Control travelling beside the divider
	typedef struct packed {
		logic       valid;
		logic [1:0] idx;
		logic       zero;
		logic       ovf_c;
		logic       ovf_r;
		logic       neg_c;
		logic       neg_r;
	} side_t;

	typedef struct packed {
		logic [9:0] col;
		logic [9:0] row;
		logic       seen;
	} vres_t;

	// Q14 product, truncated toward zero
	function automatic logic signed [PW-1:0] mulq(input logic signed [15:0] a,
			input logic signed [PW-1:0] b);
		logic signed [PW+15:0] p;
		p = a * b;
		if (p < 0)
			p = p + (PW+16)'(16383);
		return PW'(p >>> 14);
	endfunction

	// Q8 to whole units, truncated toward zero
	function automatic logic signed [DPW-1:0] div256(input logic signed [PW-1:0] v);
		logic signed [PW-1:0] t;
		t = v;
		if (v < 0)
			t = v + PW'(255);
		return DPW'(t >>> 8);
	endfunction

endpackage

FILE: hdl/tvp_trig.sv
// ----------------------------------------------------------------------------
// tvp_trig
// Sequential sine/cosine unit: rebuilds the six rotation factors with one
// shared multiplier after reset and angle writes, one factor at a time.
// ----------------------------------------------------------------------------
module tvp_trig #(
	parameter int ANGLE_BITS = 12
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	input  logic [11:0]      pitch,
	input  logic [11:0]      yaw,
	input  logic [11:0]      roll,
	output logic             busy,
	output tvp_pkg::trig_t   trig
);

	tvp_pkg::trig_state_t state_q, state_n;
	logic [2:0]          k_q;
	logic [14:0]         z_q, z2_q, t_q;
	logic                neg_q;
	logic signed [15:0]  sine_q [6];

	logic [11:0] ang;
	logic [15:0] base, phase;
	logic [14:0] z_ld;
	logic [14:0] opa, opb;
	logic [29:0] prod;
	logic [15:0] sh, sclamp;

	// Phase of the factor in hand
	always_comb begin
		case (k_q)
			3'd0, 3'd1: ang = pitch;
			3'd2, 3'd3: ang = yaw;
			default:    ang = roll;
		endcase
		base  = (16'(ang) & 16'((32'd1 << ANGLE_BITS) - 32'd1)) << (16 - ANGLE_BITS);
		phase = base + (k_q[0] ? tvp_pkg::QUARTER : 16'd0);
		z_ld  = phase[14] ? (15'(tvp_pkg::ONE_Q14) - {1'b0, phase[13:0]})
		                  : {1'b0, phase[13:0]};
	end

	// Shared multiplier
	always_comb begin
		case (state_q)
			tvp_pkg::TRIG_SQ: begin opa = z_q;  opb = z_q;  end
			tvp_pkg::TRIG_P1: begin opa = 15'(tvp_pkg::SIN_C1); opb = z2_q; end
			tvp_pkg::TRIG_P2: begin opa = t_q;  opb = z2_q; end
			default:          begin opa = t_q;  opb = z_q;  end
		endcase
		prod   = opa * opb;
		sh     = prod[29:14];
		sclamp = (sh > 16'(tvp_pkg::ONE_Q14)) ? 16'(tvp_pkg::ONE_Q14) : sh;
	end

	// Next state
	always_comb begin
		case (state_q)
			tvp_pkg::TRIG_IDLE: state_n = tvp_pkg::TRIG_IDLE;
			tvp_pkg::TRIG_LOAD: state_n = tvp_pkg::TRIG_SQ;
			tvp_pkg::TRIG_SQ:   state_n = tvp_pkg::TRIG_P1;
			tvp_pkg::TRIG_P1:   state_n = tvp_pkg::TRIG_P2;
			tvp_pkg::TRIG_P2:   state_n = tvp_pkg::TRIG_P3;
			tvp_pkg::TRIG_P3:   state_n = (k_q == 3'd5) ? tvp_pkg::TRIG_IDLE
			                                            : tvp_pkg::TRIG_LOAD;
			default:            state_n = tvp_pkg::TRIG_IDLE;
		endcase
		if (start)
			state_n = tvp_pkg::TRIG_LOAD;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= tvp_pkg::TRIG_LOAD;
			k_q     <= 3'd0;
		end else begin
			state_q <= state_n;
			if (start)
				k_q <= 3'd0;
			else if (state_q == tvp_pkg::TRIG_P3 && k_q != 3'd5)
				k_q <= k_q + 3'd1;
		end
	end

	// Datapath registers
	always_ff @(posedge clk) begin
		case (state_q)
			tvp_pkg::TRIG_LOAD: begin
				z_q   <= z_ld;
				neg_q <= phase[15];
			end
			tvp_pkg::TRIG_SQ: z2_q <= 15'(sh);
			tvp_pkg::TRIG_P1: t_q  <= 15'(16'(tvp_pkg::SIN_C2) - sh);
			tvp_pkg::TRIG_P2: t_q  <= 15'(16'(tvp_pkg::SIN_C3) - sh);
			tvp_pkg::TRIG_P3: sine_q[k_q] <= neg_q ? -$signed(sclamp) : $signed(sclamp);
			default: ;
		endcase
	end

	assign busy    = (state_q != tvp_pkg::TRIG_IDLE);
	assign trig.sx = sine_q[0];
	assign trig.cx = sine_q[1];
	assign trig.sy = sine_q[2];
	assign trig.cy = sine_q[3];
	assign trig.sz = sine_q[4];
	assign trig.cz = sine_q[5];

endmodule

FILE: hdl/tvp_front.sv
// ----------------------------------------------------------------------------
// tvp_front
// Input side: takes triangle beats, offsets each vertex by the camera in Q8
// and queues the triangle for the projection pipeline.
// ----------------------------------------------------------------------------
module tvp_front (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   in_valid,
	output logic                   in_ready,
	input  logic signed [15:0]     a_x,
	input  logic signed [15:0]     a_y,
	input  logic signed [15:0]     a_z,
	input  logic signed [15:0]     b_x,
	input  logic signed [15:0]     b_y,
	input  logic signed [15:0]     b_z,
	input  logic signed [15:0]     c_x,
	input  logic signed [15:0]     c_y,
	input  logic signed [15:0]     c_z,
	input  logic signed [23:0]     cam_x,
	input  logic signed [23:0]     cam_y,
	input  logic signed [23:0]     cam_z,
	input  logic                   trig_busy,
	input  logic                   pop,
	output logic                   head_valid,
	output tvp_pkg::tri_t          head
);

	localparam int QPW = $clog2(tvp_pkg::QDEPTH);

	tvp_pkg::tri_t       mem_q [tvp_pkg::QDEPTH];
	logic [QPW-1:0]      wr_q, rd_q;
	logic [QPW:0]        cnt_q;
	tvp_pkg::tri_t       tri_in;
	logic                push;

	function automatic logic signed [tvp_pkg::OFSW-1:0] offs(input logic signed [15:0] v,
			input logic signed [23:0] c);
		return (tvp_pkg::OFSW'(v) <<< 8) - tvp_pkg::OFSW'(c);
	endfunction

	// Camera offset of every vertex
	always_comb begin
		tri_in.a.x = offs(a_x, cam_x);
		tri_in.a.y = offs(a_y, cam_y);
		tri_in.a.z = offs(a_z, cam_z);
		tri_in.b.x = offs(b_x, cam_x);
		tri_in.b.y = offs(b_y, cam_y);
		tri_in.b.z = offs(b_z, cam_z);
		tri_in.c.x = offs(c_x, cam_x);
		tri_in.c.y = offs(c_y, cam_y);
		tri_in.c.z = offs(c_z, cam_z);
	end

	assign in_ready   = (cnt_q < (QPW+1)'(tvp_pkg::QDEPTH)) && !trig_busy;
	assign push       = in_valid && in_ready;
	assign head_valid = (cnt_q != '0);
	assign head       = mem_q[rd_q];

	// Queue pointers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push)
				wr_q <= wr_q + QPW'(1);
			if (pop)
				rd_q <= rd_q + QPW'(1);
			if (push && !pop)
				cnt_q <= cnt_q + (QPW+1)'(1);
			else if (pop && !push)
				cnt_q <= cnt_q - (QPW+1)'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (push)
			mem_q[wr_q] <= tri_in;
	end

endmodule

FILE: hdl/tvp_div.sv
// ----------------------------------------------------------------------------
// tvp_div
// Pipelined restoring divider: one quotient bit per stage. The caller must keep
// the numerator below the divisor shifted up by the quotient width; not enforced here.
// ----------------------------------------------------------------------------
module tvp_div (
	input  logic                      clk,
	input  logic                      en,
	input  logic [tvp_pkg::NW-1:0]    num,
	input  logic [tvp_pkg::DW-1:0]    den,
	output logic [tvp_pkg::QB-1:0]    quo
);

	localparam int NW = tvp_pkg::NW;
	localparam int DW = tvp_pkg::DW;
	localparam int QB = tvp_pkg::QB;

	logic [NW-1:0] rem_s [QB];
	logic [DW-1:0] den_s [QB];
	logic [QB-1:0] quo_s [QB];

	for (genvar j = 0; j < QB; j++) begin : g_stage
		logic [NW-1:0] r_in, trial;
		logic [DW-1:0] d_in;
		logic [QB-1:0] q_in;

		if (j == 0) begin : g_first
			assign r_in = num;
			assign d_in = den;
			assign q_in = '0;
		end else begin : g_next
			assign r_in = rem_s[j-1];
			assign d_in = den_s[j-1];
			assign q_in = quo_s[j-1];
		end

		assign trial = NW'(d_in) << (QB - 1 - j);

		// One quotient bit
		always_ff @(posedge clk) begin
			if (en) begin
				den_s[j] <= d_in;
				if (r_in >= trial) begin
					rem_s[j] <= r_in - trial;
					quo_s[j] <= q_in | (QB'(1) << (QB - 1 - j));
				end else begin
					rem_s[j] <= r_in;
					quo_s[j] <= q_in;
				end
			end
		end
	end

	assign quo = quo_s[QB-1];

endmodule

FILE: hdl/tvp_back.sv
// ----------------------------------------------------------------------------
// tvp_back
// Projection pipeline: issues one vertex a cycle from the queue head unless stalled,
// rotates it, forms the perspective quotients and gathers three vertices per result.
// ----------------------------------------------------------------------------
module tvp_back #(
	parameter int SCREEN_W = 800,
	parameter int SCREEN_H = 600
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 head_valid,
	input  tvp_pkg::tri_t        head,
	output logic                 pop,
	input  tvp_pkg::trig_t       trig,
	input  logic [9:0]           focal,
	output logic                 out_valid,
	input  logic                 out_ready,
	output logic [9:0]           a_col,
	output logic [9:0]           a_row,
	output logic                 a_seen,
	output logic [9:0]           b_col,
	output logic [9:0]           b_row,
	output logic                 b_seen,
	output logic [9:0]           c_col,
	output logic [9:0]           c_row,
	output logic                 c_seen,
	output logic                 all_seen
);

	localparam int PW  = tvp_pkg::PW;
	localparam int DPW = tvp_pkg::DPW;
	localparam int NW  = tvp_pkg::NW;
	localparam int DW  = tvp_pkg::DW;
	localparam int QB  = tvp_pkg::QB;

	logic en;
	logic [1:0] idx_q;

	// Issue: vertex select
	tvp_pkg::vtx_t vsel;
	always_comb begin
		case (idx_q)
			tvp_pkg::VTX_A: vsel = head.a;
			tvp_pkg::VTX_B: vsel = head.b;
			default:        vsel = head.c;
		endcase
	end

	assign pop = head_valid && en && (idx_q == tvp_pkg::VTX_C);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			idx_q <= tvp_pkg::VTX_A;
		else if (head_valid && en)
			idx_q <= (idx_q == tvp_pkg::VTX_C) ? tvp_pkg::VTX_A : idx_q + 2'd1;
	end

	// Stage valids and slot tags
	logic       v_s1, v_s2, v_s3, v_s4, v_s5, v_s6, v_s7;
	logic [1:0] i_s1, i_s2, i_s3, i_s4, i_s5, i_s6, i_s7;
	tvp_pkg::side_t side_s8;
	tvp_pkg::side_t side_s [QB];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0; v_s2 <= 1'b0; v_s3 <= 1'b0; v_s4 <= 1'b0;
			v_s5 <= 1'b0; v_s6 <= 1'b0; v_s7 <= 1'b0;
		end else if (en) begin
			v_s1 <= head_valid;
			v_s2 <= v_s1; v_s3 <= v_s2; v_s4 <= v_s3;
			v_s5 <= v_s4; v_s6 <= v_s5; v_s7 <= v_s6;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			i_s1 <= idx_q;
			i_s2 <= i_s1; i_s3 <= i_s2; i_s4 <= i_s3;
			i_s5 <= i_s4; i_s6 <= i_s5; i_s7 <= i_s6;
		end
	end

	// Roll and first half of yaw products
	logic signed [PW-1:0] mzy_s1, mcx_s1, mcy_s1, msx_s1, mcz_s1, msz_s1;
	logic signed [PW-1:0] vx, vy, vz;
	assign vx = PW'(vsel.x);
	assign vy = PW'(vsel.y);
	assign vz = PW'(vsel.z);

	always_ff @(posedge clk) begin
		if (en) begin
			mzy_s1 <= tvp_pkg::mulq(trig.sz, vy);
			mcx_s1 <= tvp_pkg::mulq(trig.cz, vx);
			mcy_s1 <= tvp_pkg::mulq(trig.cz, vy);
			msx_s1 <= tvp_pkg::mulq(trig.sz, vx);
			mcz_s1 <= tvp_pkg::mulq(trig.cy, vz);
			msz_s1 <= tvp_pkg::mulq(trig.sy, vz);
		end
	end

	// Roll sums
	logic signed [PW-1:0] p1_s2, p2_s2, mcz_s2, msz_s2;
	always_ff @(posedge clk) begin
		if (en) begin
			p1_s2  <= mzy_s1 + mcx_s1;
			p2_s2  <= mcy_s1 - msx_s1;
			mcz_s2 <= mcz_s1;
			msz_s2 <= msz_s1;
		end
	end

	// Yaw products
	logic signed [PW-1:0] a1_s3, a2_s3, p2_s3, mcz_s3, msz_s3;
	always_ff @(posedge clk) begin
		if (en) begin
			a1_s3  <= tvp_pkg::mulq(trig.sy, p1_s2);
			a2_s3  <= tvp_pkg::mulq(trig.cy, p1_s2);
			p2_s3  <= p2_s2;
			mcz_s3 <= mcz_s2;
			msz_s3 <= msz_s2;
		end
	end

	// Yaw sums
	logic signed [PW-1:0] p3_s4, dxq_s4, p2_s4;
	always_ff @(posedge clk) begin
		if (en) begin
			p3_s4  <= mcz_s3 + a1_s3;
			dxq_s4 <= a2_s3 - msz_s3;
			p2_s4  <= p2_s3;
		end
	end

	// Pitch products
	logic signed [PW-1:0]  b1_s5, b2_s5, b3_s5, b4_s5;
	logic signed [DPW-1:0] dx_s5;
	always_ff @(posedge clk) begin
		if (en) begin
			b1_s5 <= tvp_pkg::mulq(trig.sx, p3_s4);
			b2_s5 <= tvp_pkg::mulq(trig.cx, p2_s4);
			b3_s5 <= tvp_pkg::mulq(trig.cx, p3_s4);
			b4_s5 <= tvp_pkg::mulq(trig.sx, p2_s4);
			dx_s5 <= tvp_pkg::div256(dxq_s4);
		end
	end

	// Pitch sums, to whole units
	logic signed [DPW-1:0] dx_s6, dy_s6, dz_s6;
	always_ff @(posedge clk) begin
		if (en) begin
			dx_s6 <= dx_s5;
			dy_s6 <= tvp_pkg::div256(b1_s5 + b2_s5);
			dz_s6 <= tvp_pkg::div256(b3_s5 - b4_s5);
		end
	end

	// Projection numerators and denominator
	logic signed [10:0]   ez;
	logic signed [31:0]   ezdx, ezdy, wdz, hdz;
	logic signed [NW-1:0] nc_s7, nr_s7;
	logic signed [DW-1:0] den_s7;
	logic                 zero_s7;

	assign ez   = {1'b0, focal};
	assign ezdx = ez * dx_s6;
	assign ezdy = ez * dy_s6;
	assign wdz  = 32'(SCREEN_W) * dz_s6;
	assign hdz  = 32'(SCREEN_H) * dz_s6;

	always_ff @(posedge clk) begin
		if (en) begin
			nc_s7   <= (NW'(ezdx) <<< 1) + NW'(wdz);
			nr_s7   <= NW'(hdz) - (NW'(ezdy) <<< 1);
			den_s7  <= DW'(dz_s6) <<< 1;
			zero_s7 <= (dz_s6 == '0);
		end
	end

	// Magnitudes, quotient signs and range check
	logic [NW-1:0] mc, mr;
	logic [DW-1:0] md;
	assign mc = nc_s7[NW-1] ? NW'(-nc_s7) : NW'(nc_s7);
	assign mr = nr_s7[NW-1] ? NW'(-nr_s7) : NW'(nr_s7);
	assign md = den_s7[DW-1] ? DW'(-den_s7) : DW'(den_s7);

	logic [NW-1:0] mc_s8, mr_s8;
	logic [DW-1:0] md_s8;
	always_ff @(posedge clk) begin
		if (en) begin
			mc_s8 <= mc;
			mr_s8 <= mr;
			md_s8 <= md;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			side_s8 <= '0;
		else if (en) begin
			side_s8.valid <= v_s7;
			side_s8.idx   <= i_s7;
			side_s8.zero  <= zero_s7;
			side_s8.ovf_c <= mc >= (NW'(md) << QB);
			side_s8.ovf_r <= mr >= (NW'(md) << QB);
			side_s8.neg_c <= nc_s7[NW-1] ^ den_s7[DW-1];
			side_s8.neg_r <= nr_s7[NW-1] ^ den_s7[DW-1];
		end
	end

	// Column and row dividers
	logic [QB-1:0] qc, qr;
	tvp_div u_div_col (.clk(clk), .en(en), .num(mc_s8), .den(md_s8), .quo(qc));
	tvp_div u_div_row (.clk(clk), .en(en), .num(mr_s8), .den(md_s8), .quo(qr));

	// Control delay beside the dividers
	for (genvar j = 0; j < QB; j++) begin : g_side
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n)
				side_s[j] <= '0;
			else if (en)
				side_s[j] <= (j == 0) ? side_s8 : side_s[(j == 0) ? 0 : j-1];
		end
	end

	// Visibility of the finished vertex
	tvp_pkg::side_t side_f;
	tvp_pkg::vres_t vres;
	logic c_ok, r_ok, vis;
	assign side_f = side_s[QB-1];

	always_comb begin
		c_ok = !side_f.ovf_c && (side_f.neg_c ? (qc == '0) : (13'(qc) < 13'(SCREEN_W)));
		r_ok = !side_f.ovf_r && (side_f.neg_r ? (qr == '0) : (13'(qr) < 13'(SCREEN_H)));
		vis  = !side_f.zero && c_ok && r_ok;
		vres.seen = vis;
		vres.col  = vis ? qc[9:0] : 10'd0;
		vres.row  = vis ? qr[9:0] : 10'd0;
	end

	// Stall only when a finished triangle cannot leave
	assign en = !(side_f.valid && side_f.idx == tvp_pkg::VTX_C && out_valid && !out_ready);

	// Gather three vertices into the result register
	tvp_pkg::vres_t asm_a_q, asm_b_q, out_a_q, out_b_q, out_c_q;
	logic out_valid_q;

	always_ff @(posedge clk) begin
		if (en && side_f.valid) begin
			case (side_f.idx)
				tvp_pkg::VTX_A: asm_a_q <= vres;
				tvp_pkg::VTX_B: asm_b_q <= vres;
				default: begin
					out_a_q <= asm_a_q;
					out_b_q <= asm_b_q;
					out_c_q <= vres;
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_valid_q <= 1'b0;
		else if (en && side_f.valid && side_f.idx == tvp_pkg::VTX_C)
			out_valid_q <= 1'b1;
		else if (out_ready)
			out_valid_q <= 1'b0;
	end

	assign out_valid = out_valid_q;
	assign a_col     = out_a_q.col;
	assign a_row     = out_a_q.row;
	assign a_seen    = out_a_q.seen;
	assign b_col     = out_b_q.col;
	assign b_row     = out_b_q.row;
	assign b_seen    = out_b_q.seen;
	assign c_col     = out_c_q.col;
	assign c_row     = out_c_q.row;
	assign c_seen    = out_c_q.seen;
	assign all_seen  = out_a_q.seen & out_b_q.seen & out_c_q.seen;

endmodule

FILE: hdl/triangle_vertex_projector.sv
// ----------------------------------------------------------------------------
// triangle_vertex_projector
// Projects the three vertices of a triangle onto the screen through a camera
// offset, a roll/yaw/pitch rotation and a perspective divide.
//
//   channel | signals                          | beat
//   --------+----------------------------------+-----------------------------
//   in      | in_valid/in_ready, a_x..c_z      | one triangle, three vertices
//   out     | out_valid/out_ready, a_col..     | one projected triangle
//   cfg     | cfg_valid/cfg_ready, index/data  | one register write
//
// The projection pipeline takes one vertex per cycle unless stalled; each
// vertex passes the rotation stages and the 12-stage dividers before
// out_valid rises for its triangle.
// After reset and after each angle write the sine unit rebuilds its six
// factors; in_ready stays low meanwhile. cfg_ready is always high.
// A full result register stalls the pipeline only when a further triangle
// completes; a two-triangle queue keeps the input side accepting.
// ----------------------------------------------------------------------------
module triangle_vertex_projector #(
	parameter int SCREEN_W   = 800,
	parameter int SCREEN_H   = 600,
	parameter int ANGLE_BITS = 12
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                cfg_valid,
	output logic                cfg_ready,
	input  logic [2:0]          cfg_index,
	input  logic [23:0]         cfg_data,
	input  logic                in_valid,
	output logic                in_ready,
	input  logic signed [15:0]  a_x,
	input  logic signed [15:0]  a_y,
	input  logic signed [15:0]  a_z,
	input  logic signed [15:0]  b_x,
	input  logic signed [15:0]  b_y,
	input  logic signed [15:0]  b_z,
	input  logic signed [15:0]  c_x,
	input  logic signed [15:0]  c_y,
	input  logic signed [15:0]  c_z,
	output logic                out_valid,
	input  logic                out_ready,
	output logic [9:0]          a_col,
	output logic [9:0]          a_row,
	output logic                a_seen,
	output logic [9:0]          b_col,
	output logic [9:0]          b_row,
	output logic                b_seen,
	output logic [9:0]          c_col,
	output logic [9:0]          c_row,
	output logic                c_seen,
	output logic                all_seen
);

	logic signed [23:0] cam_x_q, cam_y_q, cam_z_q;
	logic [11:0]        pitch_q, yaw_q, roll_q;
	logic [9:0]         focal_q;
	logic               cfg_wr, angle_wr, trig_busy, pop, head_valid;
	tvp_pkg::trig_t     trig;
	tvp_pkg::tri_t      head;

	assign cfg_ready = 1'b1;
	assign cfg_wr    = cfg_valid && cfg_ready;
	assign angle_wr  = cfg_wr && (cfg_index == tvp_pkg::REG_PITCH
	                           || cfg_index == tvp_pkg::REG_YAW
	                           || cfg_index == tvp_pkg::REG_ROLL);

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cam_x_q <= '0;
			cam_y_q <= '0;
			cam_z_q <= '0;
			pitch_q <= '0;
			yaw_q   <= '0;
			roll_q  <= '0;
			focal_q <= tvp_pkg::FOCAL_RESET;
		end else if (cfg_wr) begin
			case (cfg_index)
				tvp_pkg::REG_CAM_X: cam_x_q <= cfg_data;
				tvp_pkg::REG_CAM_Y: cam_y_q <= cfg_data;
				tvp_pkg::REG_CAM_Z: cam_z_q <= cfg_data;
				tvp_pkg::REG_PITCH: pitch_q <= cfg_data[11:0];
				tvp_pkg::REG_YAW:   yaw_q   <= cfg_data[11:0];
				tvp_pkg::REG_ROLL:  roll_q  <= cfg_data[11:0];
				tvp_pkg::REG_FOCAL: focal_q <= cfg_data[9:0];
				default: ;
			endcase
		end
	end

	tvp_trig #(.ANGLE_BITS(ANGLE_BITS)) u_trig (
		.clk   (clk),
		.arst_n(arst_n),
		.start (angle_wr),
		.pitch (pitch_q),
		.yaw   (yaw_q),
		.roll  (roll_q),
		.busy  (trig_busy),
		.trig  (trig)
	);

	tvp_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.a_x(a_x), .a_y(a_y), .a_z(a_z),
		.b_x(b_x), .b_y(b_y), .b_z(b_z),
		.c_x(c_x), .c_y(c_y), .c_z(c_z),
		.cam_x     (cam_x_q),
		.cam_y     (cam_y_q),
		.cam_z     (cam_z_q),
		.trig_busy (trig_busy),
		.pop       (pop),
		.head_valid(head_valid),
		.head      (head)
	);

	tvp_back #(.SCREEN_W(SCREEN_W), .SCREEN_H(SCREEN_H)) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.head_valid(head_valid),
		.head      (head),
		.pop       (pop),
		.trig      (trig),
		.focal     (focal_q),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.a_col(a_col), .a_row(a_row), .a_seen(a_seen),
		.b_col(b_col), .b_row(b_row), .b_seen(b_seen),
		.c_col(c_col), .c_row(c_row), .c_seen(c_seen),
		.all_seen  (all_seen)
	);

	// Checks
	a_angle_blocks_input: assert property (@(posedge clk) disable iff (!arst_n)
		angle_wr |=> !in_ready)
		else $error("input accepted while rotation factors rebuild");

	a_unseen_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !a_seen) |-> (a_col == 10'd0 && a_row == 10'd0))
		else $error("hidden vertex carries a screen position");

	a_all_seen: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (all_seen == (a_seen && b_seen && c_seen)))
		else $error("triangle visibility disagrees with vertex flags");

endmodule
